// ===== sv/marker_detect_payload_capture_defines.svh =====
// Assertion macros for the marker detector checks
`ifndef MARKER_DETECT_PAYLOAD_CAPTURE_DEFINES_SVH
`define MARKER_DETECT_PAYLOAD_CAPTURE_DEFINES_SVH

// same-cycle implication
`define MDPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mdpc check failed");

// next-cycle implication
`define MDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mdpc check failed");

`endif

// ===== sv/mdpc_pkg.sv =====
package mdpc_pkg;

  localparam int unsigned RomDepth   = 31;
  localparam int unsigned StoreDepth = 6;
  localparam int unsigned PayloadW   = 8 * StoreDepth;

  // "##DATETIME_" + tag + "##", zero filled
  localparam logic [7:0] TIME_ROM [RomDepth] = '{
    8'd35, 8'd35, 8'd68, 8'd65, 8'd84, 8'd69, 8'd84, 8'd73, 8'd77, 8'd69, 8'd95,
    8'd71, 8'd73, 8'd71, 8'd65, 8'd51, 8'd35, 8'd35,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // "##BOOTLOADER_" + tag + "##", zero filled
  localparam logic [7:0] BOOT_ROM [RomDepth] = '{
    8'd35, 8'd35, 8'd66, 8'd79, 8'd79, 8'd84, 8'd76, 8'd79, 8'd65, 8'd68, 8'd69,
    8'd82, 8'd95, 8'd71, 8'd73, 8'd71, 8'd65, 8'd51, 8'd35, 8'd35,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [4:0] ROM_LAST = 5'd31;

  typedef struct packed {
    logic active;       // capture running before this beat
    logic active_next;  // capture running after this beat
    logic done;         // this beat was the last payload byte
  } cap_status_t;

  function automatic logic [7:0] time_rom_at(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    if (idx != ROM_LAST) begin
      ch = TIME_ROM[idx];
    end
    return ch;
  endfunction

  function automatic logic [7:0] boot_rom_at(input logic [4:0] idx);
    logic [7:0] ch;
    ch = 8'd0;
    if (idx != ROM_LAST) begin
      ch = BOOT_ROM[idx];
    end
    return ch;
  endfunction

endpackage

// ===== sv/mdpc_matcher.sv =====
module mdpc_matcher
  import mdpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [7:0] rx_byte,
  input  logic [4:0] mark_len,
  input  logic [7:0] rom_cur,
  input  logic [7:0] rom_first,
  output logic [4:0] count,
  output logic       hit
);

  logic [4:0] count_next;
  logic [4:0] count_inc;
  logic       match;

  assign match     = (rx_byte == rom_cur);
  assign count_inc = count + 5'd1;
  assign hit       = match && (count_inc == mark_len);

  // restart rule: on a miss, retry the byte against the first character only
  always_comb begin
    if (match) begin
      count_next = hit ? 5'd0 : count_inc;
    end else if (rx_byte == rom_first) begin
      count_next = 5'd1;
    end else begin
      count_next = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 5'd0;
    end else if (en) begin
      count <= count_next;
    end
  end

endmodule

// ===== sv/mdpc_capture.sv =====
module mdpc_capture
  import mdpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                start,
  input  logic [7:0]          rx_byte,
  input  logic [2:0]          payload_bytes,
  output cap_status_t         status,
  output logic [PayloadW-1:0] payload
);

  logic       active;
  logic [2:0] cap_count;
  logic [2:0] cap_count_inc;
  logic [7:0] store [StoreDepth];

  assign cap_count_inc      = cap_count + 3'd1;
  assign status.active      = active;
  assign status.done        = active && (cap_count_inc == payload_bytes);
  assign status.active_next = active ? !status.done : start;

  // packed payload includes the byte written on this beat
  always_comb begin
    payload = '0;
    for (int i = 0; i < StoreDepth; i++) begin
      if (status.done && (3'(i) < payload_bytes)) begin
        payload[8*i +: 8] = (3'(i) == cap_count) ? rx_byte : store[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cap_count <= 3'd0;
    end else if (en) begin
      active <= status.active_next;
      if (active) begin
        cap_count <= cap_count_inc;
      end else if (start) begin
        cap_count <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (en && active && (cap_count == 3'(i)) && (3'(i) < payload_bytes)) begin
        store[i] <= rx_byte;
      end
    end
  end

endmodule

// ===== sv/marker_detect_payload_capture.sv =====
// channel | handshake           | payload
// --------+---------------------+-------------------------------------------------
// in      | in_valid / in_stall | rx_byte
// out     | out_valid/out_stall | reboot_request capture_started capture_done
//         |                     | capturing payload
//
// One byte per cycle while the output is not stalled; a byte passes the input
// register, then the matcher/capture logic, on its way to the result register.
// Matcher counts and capture state advance only when a beat moves into the
// result register. Synchronous reset clears all control state.
// A stalled output holds its beat; the input register keeps taking bytes
// until both stages are full.
module marker_detect_payload_capture
  import mdpc_pkg::*;
#(
  parameter int unsigned TIME_MARK_LEN = 18,
  parameter int unsigned BOOT_MARK_LEN = 20,
  parameter int unsigned PAYLOAD_BYTES = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                reboot_request,
  output logic                capture_started,
  output logic                capture_done,
  output logic                capturing,
  output logic [PayloadW-1:0] payload
);

  logic                in_full;
  logic [7:0]          byte_q;
  logic                advance;
  logic                match_en;
  logic [4:0]          time_count;
  logic [4:0]          boot_count;
  logic                time_hit;
  logic                boot_hit;
  cap_status_t         cap_status;
  logic [PayloadW-1:0] cap_payload;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && out_valid && out_stall;
  assign match_en = advance && !cap_status.active;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  mdpc_matcher u_time_match (
    .clk       (clk),
    .rst       (rst),
    .en        (match_en),
    .rx_byte   (byte_q),
    .mark_len  (5'(TIME_MARK_LEN)),
    .rom_cur   (time_rom_at(time_count)),
    .rom_first (time_rom_at(5'd0)),
    .count     (time_count),
    .hit       (time_hit)
  );

  mdpc_matcher u_boot_match (
    .clk       (clk),
    .rst       (rst),
    .en        (match_en),
    .rx_byte   (byte_q),
    .mark_len  (5'(BOOT_MARK_LEN)),
    .rom_cur   (boot_rom_at(boot_count)),
    .rom_first (boot_rom_at(5'd0)),
    .count     (boot_count),
    .hit       (boot_hit)
  );

  mdpc_capture u_capture (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .start         (time_hit && !cap_status.active),
    .rx_byte       (byte_q),
    .payload_bytes (3'(PAYLOAD_BYTES)),
    .status        (cap_status),
    .payload       (cap_payload)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      reboot_request  <= boot_hit && !cap_status.active;
      capture_started <= time_hit && !cap_status.active;
      capture_done    <= cap_status.done;
      capturing       <= cap_status.active_next;
      payload         <= cap_payload;
    end
  end

endmodule

// ===== sv/mdpc_checker.sv =====
`include "marker_detect_payload_capture_defines.svh"

module mdpc_checker
  import mdpc_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic                reboot_request,
  input logic                capture_started,
  input logic                capture_done,
  input logic                capturing,
  input logic [PayloadW-1:0] payload
);

  `MDPC_ASSERT_IMPLY(a_done_ends_capture, clk, rst, out_valid && capture_done,
                     !capturing && !capture_started && !reboot_request)
  `MDPC_ASSERT_IMPLY(a_start_begins_capture, clk, rst, out_valid && capture_started,
                     capturing)
  `MDPC_ASSERT_IMPLY(a_payload_only_on_done, clk, rst, out_valid && !capture_done,
                     payload == '0)
  `MDPC_ASSERT_NEXT(a_stalled_beat_holds, clk, rst, out_valid && out_stall,
                    out_valid && $stable(payload) && $stable(capturing))
  `MDPC_ASSERT_IMPLY(a_in_stall_only_when_blocked, clk, rst, in_stall,
                     out_valid && out_stall)

endmodule

bind marker_detect_payload_capture mdpc_checker u_mdpc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .reboot_request  (reboot_request),
  .capture_started (capture_started),
  .capture_done    (capture_done),
  .capturing       (capturing),
  .payload         (payload)
);

// ===== tb/marker_detect_payload_capture_test.sv =====
`timescale 1ns / 1ps

module marker_detect_payload_capture_test;
  import mdpc_pkg::*;

  localparam int unsigned TIME_LEN     = 18;
  localparam int unsigned BOOT_LEN     = 20;
  localparam int unsigned PAY_BYTES    = 6;
  localparam int unsigned RANDOM_BEATS = 650;
  localparam int unsigned DIR_N        = 28;

  typedef struct packed {
    logic                reboot;
    logic                started;
    logic                done;
    logic                active;
    logic [PayloadW-1:0] data;
  } marker_result_t;

  typedef struct packed {
    logic [7:0]     ch;
    logic           typed;
    marker_result_t want;
  } beat_row_t;

  localparam marker_result_t NO_EVENT = '{1'b0, 1'b0, 1'b0, 1'b0, 48'h0};
  localparam marker_result_t STARTED  = '{1'b0, 1'b1, 1'b0, 1'b1, 48'h0};

  // extremes after reset, a broken "###" lead that must restart the time
  // matcher, the rest of the time marker, then a payload holding marker chars
  localparam beat_row_t DIRECTED [DIR_N] = '{
    '{8'h00, 1'b1, NO_EVENT},
    '{8'hFF, 1'b1, NO_EVENT},
    '{8'h23, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h44, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'h54, 1'b0, '0},
    '{8'h45, 1'b0, '0},
    '{8'h54, 1'b0, '0},
    '{8'h49, 1'b0, '0},
    '{8'h4D, 1'b0, '0},
    '{8'h45, 1'b0, '0},
    '{8'h5F, 1'b0, '0},
    '{8'h47, 1'b0, '0},
    '{8'h49, 1'b0, '0},
    '{8'h47, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'h33, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h23, 1'b1, STARTED},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h23, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 48'hFF5A_2323_8000}}
  };

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [7:0]          rx_byte   = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                reboot_request;
  logic                capture_started;
  logic                capture_done;
  logic                capturing;
  logic [PayloadW-1:0] payload;

  marker_detect_payload_capture #(
    .TIME_MARK_LEN(TIME_LEN),
    .BOOT_MARK_LEN(BOOT_LEN),
    .PAYLOAD_BYTES(PAY_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .reboot_request(reboot_request),
    .capture_started(capture_started),
    .capture_done(capture_done),
    .capturing(capturing),
    .payload(payload)
  );

  // matcher and capture state of the predictor
  logic [4:0]     time_cnt = '0;
  logic [4:0]     boot_cnt = '0;
  logic           cap_on   = 1'b0;
  logic [2:0]     cap_idx  = '0;
  logic [7:0]     cap_bytes [StoreDepth];

  marker_result_t pending_results [$];
  logic [7:0]     seq_q [$];
  bit             calm = 1'b0;
  int unsigned    failures = 0;
  int unsigned    random_beats = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("marker_detect_payload_capture_test: FAIL");
    $finish;
  end

  // restart rule: on a miss the same byte is tried against the first char
  function automatic bit step_matcher(input logic [7:0] ch, input logic [7:0] want,
                                      input logic [7:0] first, input int unsigned len,
                                      inout logic [4:0] cnt);
    bit hit;
    hit = 1'b0;
    if (ch == want) begin
      if (int'(cnt) + 1 == len) begin
        cnt = '0;
        hit = 1'b1;
      end else begin
        cnt = cnt + 5'd1;
      end
    end else begin
      cnt = (ch == first) ? 5'd1 : 5'd0;
    end
    return hit;
  endfunction

  function automatic marker_result_t predict_beat(input logic [7:0] ch);
    marker_result_t r;
    logic [2:0]     k;
    int             i;
    r = '0;
    if (cap_on) begin
      k = cap_idx;
      if (k < PAY_BYTES) cap_bytes[k] = ch;
      k = k + 3'd1;
      cap_idx = k;
      if (k == PAY_BYTES) begin
        r.done = 1'b1;
        cap_on = 1'b0;
        for (i = 0; i < PAY_BYTES; i++) r.data[8*i +: 8] = cap_bytes[i];
      end
    end else begin
      if (step_matcher(ch, TIME_ROM[time_cnt], TIME_ROM[0], TIME_LEN, time_cnt)) begin
        r.started = 1'b1;
        cap_on = 1'b1;
        cap_idx = '0;
      end
      if (step_matcher(ch, BOOT_ROM[boot_cnt], BOOT_ROM[0], BOOT_LEN, boot_cnt))
        r.reboot = 1'b1;
    end
    r.active = cap_on;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 3))
      0: return 8'h23;
      1: return TIME_ROM[$urandom_range(0, TIME_LEN - 1)];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] ch, input bit typed, input marker_result_t want);
    marker_result_t predicted;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= ch;
    do @(posedge clk); while (in_stall);
    predicted = predict_beat(ch);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_for_results(input int unsigned limit);
    int unsigned n;
    n = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && n < limit) begin
      @(negedge clk);
      n++;
    end
    @(posedge clk);
  endtask

  // mostly whole markers, time markers with a random payload; the rest truncated markers and noise
  task automatic build_sequence();
    int unsigned r, cut, i;
    bit          use_time;
    r = $urandom_range(0, 99);
    use_time = $urandom_range(0, 1);
    // a stray lead '#' breaks the marker through the restart rule
    if (r < 75 && $urandom_range(0, 3) == 0) seq_q.push_back(8'h23);
    if (r < 35) begin
      for (i = 0; i < TIME_LEN; i++) seq_q.push_back(TIME_ROM[i]);
      for (i = 0; i < PAY_BYTES; i++) seq_q.push_back(random_byte());
    end else if (r < 60) begin
      for (i = 0; i < BOOT_LEN; i++) seq_q.push_back(BOOT_ROM[i]);
    end else if (r < 75) begin
      cut = use_time ? $urandom_range(1, TIME_LEN - 1) : $urandom_range(1, BOOT_LEN - 1);
      for (i = 0; i < cut; i++) seq_q.push_back(use_time ? TIME_ROM[i] : BOOT_ROM[i]);
      seq_q.push_back(random_byte());
    end else begin
      repeat ($urandom_range(1, 8)) seq_q.push_back(random_byte());
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 29);
  end

  always @(posedge clk) begin
    marker_result_t got;
    marker_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{reboot_request, capture_started, capture_done, capturing, payload};
      if (pending_results.size() == 0) begin
        if (failures < 10)
          $display("unexpected beat: reboot=%0b start=%0b done=%0b cap=%0b payload=%h",
                   got.reboot, got.started, got.done, got.active, got.data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (failures < 10)
            $display({"mismatch: reboot %0b/%0b start %0b/%0b done %0b/%0b",
                      " cap %0b/%0b payload %h/%h (exp/act)"},
                     want.reboot, got.reboot, want.started, got.started,
                     want.done, got.done, want.active, got.active, want.data, got.data);
          failures++;
        end
      end
    end
  end

  initial begin
    int i;
    foreach (cap_bytes[i]) cap_bytes[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++) send_beat(DIRECTED[i].ch, DIRECTED[i].typed, DIRECTED[i].want);
    wait_for_results(2000);

    while (random_beats < RANDOM_BEATS) begin
      build_sequence();
      while (seq_q.size() != 0) begin
        calm = random_beats >= 200 && random_beats < 350;
        if (random_beats == 450) wait_for_results(2000);
        send_beat(seq_q.pop_front(), 1'b0, '0);
        random_beats++;
      end
    end
    calm = 1'b0;

    wait_for_results(2000);
    if (pending_results.size() != 0) begin
      if (failures < 10) $display("%0d results never arrived", pending_results.size());
      failures += pending_results.size();
    end
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("marker_detect_payload_capture_test: PASS");
    end else begin
      $display("marker_detect_payload_capture_test: FAIL");
    end
    $finish;
  end

endmodule
